### rtl/sps_pkg.sv
// Shared types, constants and the coil lookup for the stepper position sequencer.
package sps_pkg;

   localparam int SPS_POSITION_BITS = 32;
   localparam int SPS_COUNT_BITS    = 16;
   localparam int SPS_OUT_POS_BITS  = 32;
   localparam int SPS_COIL_BITS     = 4;
   localparam int SPS_ADDR_BITS     = 4;
   localparam int SPS_DATA_BITS     = 32;

   typedef enum logic [1:0] {
      ACT_TICK     = 2'd0,
      ACT_FORWARD  = 2'd1,
      ACT_BACKWARD = 2'd2,
      ACT_STOP     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_FULL_STEP = 2'd0,
      REG_FREE_RUN  = 2'd1,
      REG_PAUSE     = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic full_step;
      logic free_run;
      logic pause;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{full_step: 1'b1, free_run: 1'b0, pause: 1'b0};

   localparam logic [SPS_COIL_BITS-1:0] PHASE_TABLE [8] = '{
      4'b0001, 4'b0011, 4'b0010, 4'b0110,
      4'b0100, 4'b1100, 4'b1000, 4'b1001
   };

   localparam logic [2:0] PHASE_MASK      = 3'h7;
   localparam logic [2:0] FULL_STEP_MASK  = 3'h6;

   // Active-low coil pattern for the low position bits.
   function automatic logic [SPS_COIL_BITS-1:0] coil_pattern(input logic [2:0] idx,
                                                             input logic       full);
      logic [2:0] sel;
      sel = idx & PHASE_MASK;
      if (full) begin
         sel = sel & FULL_STEP_MASK;
      end
      return ~PHASE_TABLE[sel];
   endfunction

   localparam logic [SPS_COIL_BITS-1:0] COIL_RESET = ~PHASE_TABLE[0];

endpackage

### rtl/sps_chan_if.sv
// Valid/ready channel interfaces for command words and result words.
interface stepper_req_if
   import sps_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [1:0]                action;
   logic [SPS_COUNT_BITS-1:0] step_count;

   modport source (output valid, output action, output step_count, input ready);
   modport sink   (input valid, input action, input step_count, output ready);
endinterface

interface stepper_rsp_if
   import sps_pkg::*;
();
   logic                               valid;
   logic                               ready;
   logic [SPS_COIL_BITS-1:0]           coil_drive;
   logic signed [SPS_OUT_POS_BITS-1:0] position;
   logic                               moving;

   modport source (output valid, output coil_drive, output position, output moving,
                   input ready);
   modport sink   (input valid, input coil_drive, input position, input moving,
                   output ready);
endinterface

### rtl/sps_csr.sv
// APB register file holding the full_step, free_run and pause controls.
module sps_csr
   import sps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [SPS_ADDR_BITS-1:0] paddr,
   input  logic [SPS_DATA_BITS-1:0] pwdata,
   output logic [SPS_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[SPS_ADDR_BITS-1:2]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_FULL_STEP: cfg_in.full_step = pwdata[0];
            REG_FREE_RUN:  cfg_in.free_run  = pwdata[0];
            REG_PAUSE:     cfg_in.pause     = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FULL_STEP: prdata = SPS_DATA_BITS'(cfg_ff.full_step);
         REG_FREE_RUN:  prdata = SPS_DATA_BITS'(cfg_ff.free_run);
         REG_PAUSE:     prdata = SPS_DATA_BITS'(cfg_ff.pause);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/sps_core.sv
// Command register, position/target update and result register of the sequencer.
module sps_core
   import sps_pkg::*;
#(
   parameter int POSITION_BITS = SPS_POSITION_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   stepper_req_if.sink   req_chan,
   stepper_rsp_if.source rsp_chan
);

   // command register
   logic                      cmd_valid_ff;
   logic                      cmd_valid_in;
   action_type                cmd_action_ff;
   action_type                cmd_action_in;
   logic [SPS_COUNT_BITS-1:0] cmd_count_ff;
   logic [SPS_COUNT_BITS-1:0] cmd_count_in;

   // motion state, which also serves as the result register
   logic [POSITION_BITS-1:0]  cur_ff;
   logic [POSITION_BITS-1:0]  cur_in;
   logic [POSITION_BITS-1:0]  tgt_ff;
   logic [POSITION_BITS-1:0]  tgt_in;
   logic [SPS_COIL_BITS-1:0]  coil_ff;
   logic [SPS_COIL_BITS-1:0]  coil_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   logic                      out_free;
   logic                      advance;
   logic                      req_take;
   logic                      step_up;
   logic                      step_dn;
   logic [POSITION_BITS-1:0]  cur_inc;
   logic [POSITION_BITS-1:0]  cur_dec;
   logic [POSITION_BITS-1:0]  count_ext;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = cmd_valid_ff && out_free;
   assign req_chan.ready = !cmd_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      cmd_valid_in  = cmd_valid_ff;
      cmd_action_in = cmd_action_ff;
      cmd_count_in  = cmd_count_ff;
      if (req_take) begin
         cmd_valid_in  = 1'b1;
         cmd_action_in = action_type'(req_chan.action);
         cmd_count_in  = req_chan.step_count;
      end else if (out_free) begin
         cmd_valid_in  = 1'b0;
      end
   end

   assign rsp_valid_in = out_free ? cmd_valid_ff : rsp_valid_ff;

   assign step_up   = $signed(cur_ff) < $signed(tgt_ff);
   assign step_dn   = $signed(tgt_ff) < $signed(cur_ff);
   assign cur_inc   = cur_ff + POSITION_BITS'(1);
   assign cur_dec   = cur_ff - POSITION_BITS'(1);
   assign count_ext = POSITION_BITS'(cmd_count_ff);

   always_comb begin
      cur_in  = cur_ff;
      tgt_in  = tgt_ff;
      coil_in = coil_ff;
      if (advance) begin
         unique case (cmd_action_ff)
            ACT_FORWARD:  tgt_in = tgt_ff + count_ext;
            ACT_BACKWARD: tgt_in = tgt_ff - count_ext;
            ACT_STOP:     tgt_in = cur_ff;
            ACT_TICK: begin
               // coil pattern latches only when a step is taken
               if (!cfg.pause && step_up) begin
                  cur_in  = cur_inc;
                  coil_in = coil_pattern(cur_inc[2:0], cfg.full_step);
                  if (cfg.free_run) begin
                     tgt_in = tgt_ff + POSITION_BITS'(1);
                  end
               end else if (!cfg.pause && step_dn) begin
                  cur_in  = cur_dec;
                  coil_in = coil_pattern(cur_dec[2:0], cfg.full_step);
                  if (cfg.free_run) begin
                     tgt_in = tgt_ff - POSITION_BITS'(1);
                  end
               end
            end
            default: cur_in = cur_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         tgt_ff       <= '0;
         coil_ff      <= COIL_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         coil_ff      <= coil_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_action_ff <= cmd_action_in;
      cmd_count_ff  <= cmd_count_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.coil_drive = coil_ff;
   // sign-extend or keep the low word, depending on the position width
   assign rsp_chan.position   = SPS_OUT_POS_BITS'($signed(cur_ff));
   assign rsp_chan.moving     = cur_ff != tgt_ff;

endmodule

### rtl/stepper_position_sequencer.sv
// Top level of the four-coil stepper position sequencer.
//
// Usage:
//   req_chan carries one command word: action (tick, forward, backward, stop)
//   and step_count, used by forward and backward only.
//   rsp_chan returns one result word for every command word: the active-low
//   coil pattern, the current position (32 bits) and a moving flag.
//   The APB port (psel .. pready) holds full_step at 0x0, free_run at 0x4 and
//   pause at 0x8; writes elsewhere are dropped. pready is always high.
//   Change the controls only while no word is in flight.
// Timing:
//   A command word enters a command register; once the result register is free it is
//   applied to the position, target and coil registers, which hold the result.
//   One word per cycle is taken sustained while rsp_chan is ready; the command register
//   and the result register each hold one word.
// Reset (synchronous, active high): position and target return to zero, the
//   coil pattern to 4'hE, full_step to 1, free_run and pause to 0.
// Stall: while rsp_chan is held off, the result stays put and one further word
//   is accepted into the command register; then req_chan.ready drops.
module stepper_position_sequencer
   import sps_pkg::*;
#(
   parameter int POSITION_BITS = SPS_POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   stepper_req_if.sink              req_chan,
   stepper_rsp_if.source            rsp_chan,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [SPS_ADDR_BITS-1:0] paddr,
   input  logic [SPS_DATA_BITS-1:0] pwdata,
   output logic [SPS_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type cfg;

   sps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sps_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/sps_checker.sv
// Port-level assertions for the stepper position sequencer, bound to the top level.
module sps_checker
   import sps_pkg::*;
(
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [SPS_COIL_BITS-1:0]           coil_drive,
   input logic signed [SPS_OUT_POS_BITS-1:0] position
);

   logic rsp_take;
   assign rsp_take = rsp_valid && rsp_ready;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(position) && $stable(coil_drive))
      else $error("result word changed while stalled");

   // an empty result register never blocks the command side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("command side blocked with result register empty");

   // each word moves the position by at most one step
   a_single_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && $past(rsp_take) && !$past(reset) |->
         (position == $past(position)) ||
         (position == $past(position) + 32'sd1) ||
         (position == $past(position) - 32'sd1))
      else $error("position jumped by more than one step");

   // coils change only with a step
   a_coil_tracks_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && $past(rsp_take) && !$past(reset) && (position == $past(position)) |->
         coil_drive == $past(coil_drive))
      else $error("coil pattern changed without a step");

   // at least one coil is always energised
   a_coil_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> coil_drive != 4'hF)
      else $error("no coil driven");

endmodule

bind stepper_position_sequencer sps_checker u_sps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .coil_drive (rsp_chan.coil_drive),
   .position   (rsp_chan.position)
);
